// File: src/gpio_pid_pkg.sv
// ----------------------------------------------------------------------------
// gpio_pid_pkg
// Shared types and constants for the GPIO port with edge and level interrupt
// detection.
// ----------------------------------------------------------------------------
package gpio_pid_pkg;

   localparam int PIN_COUNT = 8;
   localparam int PinWidth  = 8;
   localparam logic [PinWidth-1:0] PinMask =
      PinWidth'((64'd1 << PIN_COUNT) - 64'd1);

   typedef logic [PinWidth-1:0] pins_type;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_READ  = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_DATA       = 3'd0,
      REG_DIRECTION  = 3'd1,
      REG_MASK       = 3'd2,
      REG_RAW_STATUS = 3'd3,
      REG_MASKED     = 3'd4,
      REG_CLEAR      = 3'd5,
      REG_ALTFUNC    = 3'd6,
      REG_DIGITAL_EN = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      CSR_LEVEL_SENSE    = 2'd0,
      CSR_BOTH_EDGES     = 2'd1,
      CSR_HIGH_OR_RISING = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

endpackage

// File: src/gpio_port_interrupt_detect.sv
// Path: an accepted req word passes the input register, then the result register,
// to its rsp word. Throughput: one word per cycle while rsp is not stalled, set by
// the single combinational pass from the input register to the result register.
// Reset: synchronous, active high; clears all pin state, status, mask and
// sense configuration, and empties both registers.
// ----------------------------------------------------------------------------
// gpio_port_interrupt_detect
// Eight-pin GPIO port: pin-sample ticks, register reads and writes, per-pin
// level or edge interrupt detection, masked status and an irq flag.
// ----------------------------------------------------------------------------
module gpio_port_interrupt_detect (
   input  logic        clock,
   input  logic        reset,
   // req
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // reg_index[2:0], write_data[10:3], pin_levels[18:11]
   input  logic [1:0]  req_tuser,   // action[1:0]
   // rsp
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_data[7:0], irq[8]
   // csr
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   typedef gpio_pid_pkg::pins_type pins_type;

   // configuration
   pins_type level_sense_ff, both_edges_ff, high_or_rising_ff;

   // port state
   pins_type previous_pins_ff, previous_pins_in;
   pins_type raw_status_ff, raw_status_in;
   pins_type irq_mask_ff, irq_mask_in;
   pins_type pin_direction_ff, pin_direction_in;
   pins_type output_latch_ff, output_latch_in;
   pins_type alt_select_ff, alt_select_in;
   pins_type digital_enable_ff, digital_enable_in;

   // input register
   logic                       in_valid_ff;
   gpio_pid_pkg::action_type    action_ff;
   gpio_pid_pkg::reg_index_type reg_index_ff;
   pins_type                   write_data_ff;
   pins_type                   pin_levels_ff;

   // result register
   logic     rsp_valid_ff;
   pins_type read_data_ff, read_data_in;
   logic     irq_ff, irq_in;

   logic advance;
   pins_type rise, fall, lvl_hit, one_edge, edge_hit, hits;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, irq_ff, read_data_ff};

   always_comb begin
      rise     = pin_levels_ff & ~previous_pins_ff;
      fall     = ~pin_levels_ff & previous_pins_ff;
      lvl_hit  = (pin_levels_ff & high_or_rising_ff) | (~pin_levels_ff & ~high_or_rising_ff);
      one_edge = (rise & high_or_rising_ff) | (fall & ~high_or_rising_ff);
      edge_hit = (both_edges_ff & (rise | fall)) | (~both_edges_ff & one_edge);
      hits     = (level_sense_ff & lvl_hit) | (~level_sense_ff & edge_hit);

      previous_pins_in  = previous_pins_ff;
      raw_status_in     = raw_status_ff;
      irq_mask_in       = irq_mask_ff;
      pin_direction_in  = pin_direction_ff;
      output_latch_in   = output_latch_ff;
      alt_select_in     = alt_select_ff;
      digital_enable_in = digital_enable_ff;
      read_data_in      = '0;

      case (action_ff)
         gpio_pid_pkg::ACT_TICK: begin
            raw_status_in    = (raw_status_ff | hits) & gpio_pid_pkg::PinMask;
            previous_pins_in = pin_levels_ff;
         end
         gpio_pid_pkg::ACT_READ: begin
            case (reg_index_ff)
               gpio_pid_pkg::REG_DATA:
                  read_data_in = ((output_latch_ff & pin_direction_ff) |
                                  (previous_pins_ff & ~pin_direction_ff)) &
                                 gpio_pid_pkg::PinMask;
               gpio_pid_pkg::REG_DIRECTION:  read_data_in = pin_direction_ff;
               gpio_pid_pkg::REG_MASK:       read_data_in = irq_mask_ff;
               gpio_pid_pkg::REG_RAW_STATUS: read_data_in = raw_status_ff;
               gpio_pid_pkg::REG_MASKED:     read_data_in = raw_status_ff & irq_mask_ff;
               gpio_pid_pkg::REG_ALTFUNC:    read_data_in = alt_select_ff;
               gpio_pid_pkg::REG_DIGITAL_EN: read_data_in = digital_enable_ff;
               default:                      read_data_in = '0;
            endcase
         end
         gpio_pid_pkg::ACT_WRITE: begin
            case (reg_index_ff)
               gpio_pid_pkg::REG_DATA:       output_latch_in   = write_data_ff;
               gpio_pid_pkg::REG_DIRECTION:  pin_direction_in  = write_data_ff;
               gpio_pid_pkg::REG_MASK:       irq_mask_in       = write_data_ff;
               gpio_pid_pkg::REG_CLEAR:      raw_status_in     = raw_status_ff & ~write_data_ff;
               gpio_pid_pkg::REG_ALTFUNC:    alt_select_in     = write_data_ff;
               gpio_pid_pkg::REG_DIGITAL_EN: digital_enable_in = write_data_ff;
               default: ;
            endcase
         end
         default: ;
      endcase

      irq_in = |(raw_status_in & irq_mask_in & gpio_pid_pkg::PinMask);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         level_sense_ff    <= '0;
         both_edges_ff     <= '0;
         high_or_rising_ff <= '0;
         previous_pins_ff  <= '0;
         raw_status_ff     <= '0;
         irq_mask_ff       <= '0;
         pin_direction_ff  <= '0;
         output_latch_ff   <= '0;
         alt_select_ff     <= '0;
         digital_enable_ff <= '0;
      end else begin
         // input register
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         // result register
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         // commit state
         if (advance) begin
            previous_pins_ff  <= previous_pins_in;
            raw_status_ff     <= raw_status_in;
            irq_mask_ff       <= irq_mask_in;
            pin_direction_ff  <= pin_direction_in;
            output_latch_ff   <= output_latch_in;
            alt_select_ff     <= alt_select_in;
            digital_enable_ff <= digital_enable_in;
         end

         if (csr_valid && csr_ready) begin
            case (gpio_pid_pkg::csr_index_type'(csr_index))
               gpio_pid_pkg::CSR_LEVEL_SENSE:
                  level_sense_ff <= csr_data & gpio_pid_pkg::PinMask;
               gpio_pid_pkg::CSR_BOTH_EDGES:
                  both_edges_ff <= csr_data & gpio_pid_pkg::PinMask;
               gpio_pid_pkg::CSR_HIGH_OR_RISING:
                  high_or_rising_ff <= csr_data & gpio_pid_pkg::PinMask;
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         action_ff     <= gpio_pid_pkg::action_type'(req_tuser);
         reg_index_ff  <= gpio_pid_pkg::reg_index_type'(req_tdata[2:0]);
         write_data_ff <= req_tdata[10:3] & gpio_pid_pkg::PinMask;
         pin_levels_ff <= req_tdata[18:11] & gpio_pid_pkg::PinMask;
      end
      if (advance) begin
         read_data_ff <= read_data_in;
         irq_ff       <= irq_in;
      end
   end

endmodule

// File: test/gpio_port_interrupt_detect_checker.sv
// ----------------------------------------------------------------------------
// gpio_port_interrupt_detect_checker
// Watches the req, rsp and csr channels of the GPIO port. Keeps its own copy
// of the sense configuration, pin history, status and port registers. Works
// out the read data and irq flag for every accepted req word, and compares
// each accepted rsp word, field by field, with the oldest pending prediction.
// ----------------------------------------------------------------------------
module gpio_port_interrupt_detect_checker
   import gpio_pid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          mismatch_count,
   output int          results_waiting
);

   typedef struct packed {
      pins_type read_data;
      logic     irq;
   } port_result_type;

   pins_type level_sense;
   pins_type both_edges;
   pins_type high_or_rising;
   pins_type previous_pins;
   pins_type raw_status;
   pins_type irq_mask;
   pins_type pin_direction;
   pins_type output_latch;
   pins_type alt_select;
   pins_type digital_enable;

   port_result_type pending_results[$];

   initial begin
      mismatch_count  = 0;
      results_waiting = 0;
   end

   function automatic port_result_type predict_port_word(action_type action,
                                                         reg_index_type idx,
                                                         pins_type wdata,
                                                         pins_type pins);
      pins_type        rise;
      pins_type        fall;
      pins_type        level_hit;
      pins_type        single_edge;
      pins_type        edge_hit;
      port_result_type res;
      res.read_data = '0;
      wdata = wdata & PinMask;
      pins  = pins & PinMask;
      case (action)
         ACT_TICK: begin
            rise        = pins & ~previous_pins;
            fall        = ~pins & previous_pins;
            level_hit   = (pins & high_or_rising) | (~pins & ~high_or_rising);
            single_edge = (rise & high_or_rising) | (fall & ~high_or_rising);
            edge_hit    = (both_edges & (rise | fall)) | (~both_edges & single_edge);
            raw_status  = (raw_status | (level_sense & level_hit)
                          | (~level_sense & edge_hit)) & PinMask;
            previous_pins = pins;
         end
         ACT_READ: begin
            case (idx)
               REG_DATA:       res.read_data = ((output_latch & pin_direction)
                                               | (previous_pins & ~pin_direction)) & PinMask;
               REG_DIRECTION:  res.read_data = pin_direction;
               REG_MASK:       res.read_data = irq_mask;
               REG_RAW_STATUS: res.read_data = raw_status;
               REG_MASKED:     res.read_data = raw_status & irq_mask;
               REG_ALTFUNC:    res.read_data = alt_select;
               REG_DIGITAL_EN: res.read_data = digital_enable;
               default:        res.read_data = '0;
            endcase
         end
         ACT_WRITE: begin
            case (idx)
               REG_DATA:       output_latch   = wdata;
               REG_DIRECTION:  pin_direction  = wdata;
               REG_MASK:       irq_mask       = wdata;
               REG_CLEAR:      raw_status     = raw_status & ~wdata;
               REG_ALTFUNC:    alt_select     = wdata;
               REG_DIGITAL_EN: digital_enable = wdata;
               default: ;
            endcase
         end
         default: ;
      endcase
      res.irq = |(raw_status & irq_mask & PinMask);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      port_result_type got;
      port_result_type want;
      if (reset) begin
         level_sense    = '0;
         both_edges     = '0;
         high_or_rising = '0;
         previous_pins  = '0;
         raw_status     = '0;
         irq_mask       = '0;
         pin_direction  = '0;
         output_latch   = '0;
         alt_select     = '0;
         digital_enable = '0;
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_LEVEL_SENSE:    level_sense    = csr_data & PinMask;
               CSR_BOTH_EDGES:     both_edges     = csr_data & PinMask;
               CSR_HIGH_OR_RISING: high_or_rising = csr_data & PinMask;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.read_data = rsp_tdata[7:0];
            got.irq       = rsp_tdata[8];
            if (pending_results.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               $display("%0t: unexpected rsp word, expected none, actual read_data %02h irq %0b",
                        $time, got.read_data, got.irq);
            end else begin
               want = pending_results.pop_front();
               if (got.read_data !== want.read_data) begin
                  mismatch_count = mismatch_count + 1;
                  $display("%0t: read_data mismatch, expected %02h, actual %02h",
                           $time, want.read_data, got.read_data);
               end
               if (got.irq !== want.irq) begin
                  mismatch_count = mismatch_count + 1;
                  $display("%0t: irq mismatch, expected %0b, actual %0b",
                           $time, want.irq, got.irq);
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(predict_port_word(action_type'(req_tuser),
                                                        reg_index_type'(req_tdata[2:0]),
                                                        req_tdata[10:3], req_tdata[18:11]));
      end
      results_waiting = pending_results.size();
   end

endmodule

// File: test/gpio_port_interrupt_detect_test.sv
// ----------------------------------------------------------------------------
// gpio_port_interrupt_detect_test
// Drives the GPIO port with directed and random pin ticks, register reads,
// register writes and unused actions under several sense settings and idle
// patterns, including a long rsp hold-off. A checker beside the block does
// the prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module gpio_port_interrupt_detect_test;
   import gpio_pid_pkg::*;

   localparam int CycleLimit    = 200000;
   localparam int HoldOffCycles = 300;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;   // reg_index[2:0], write_data[10:3], pin_levels[18:11]
   logic [1:0]  req_tuser   = '0;   // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // read_data[7:0], irq[8]
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index   = '0;
   logic [7:0]  csr_data    = '0;

   int       mismatch_count;
   int       results_waiting;
   int       send_idle_pct  = 0;
   int       recv_stall_pct = 0;
   int       hold_id        = 0;
   int       hold_seen      = 0;
   int       hold_count     = 0;
   int       cycle_count    = 0;
   pins_type last_pins      = '0;

   gpio_port_interrupt_detect DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   gpio_port_interrupt_detect_checker port_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .results_waiting (results_waiting)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("gpio_port_interrupt_detect test failed");
         $finish;
      end
   end

   // hold rsp off for a long stretch on request, else stall at random
   always @(posedge clock) begin
      if (hold_count != 0) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count - 1;
      end else if (hold_id != hold_seen) begin
         hold_seen  <= hold_id;
         hold_count <= HoldOffCycles;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_word(action_type action, reg_index_type idx, pins_type wdata,
                            pins_type pins);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {5'd0, pins, wdata, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, pins_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_sense(pins_type level, pins_type both, pins_type rising);
      write_csr(CSR_LEVEL_SENSE, level);
      write_csr(CSR_BOTH_EDGES, both);
      write_csr(CSR_HIGH_OR_RISING, rising);
   endtask

   task automatic send_random_word;
      int       pick;
      pins_type pins;
      pick = $urandom_range(99);
      if (pick < 45) begin
         case ($urandom_range(3))
            0: pins = pins_type'($urandom_range(255));
            1: pins = last_pins;
            2: pins = last_pins ^ pins_type'(8'd1 << $urandom_range(7));
            default: pins = $urandom_range(1) ? 8'hFF : 8'h00;
         endcase
         last_pins = pins;
         send_word(ACT_TICK, reg_index_type'($urandom_range(7)),
                   pins_type'($urandom_range(255)), pins);
      end else if (pick < 70) begin
         send_word(ACT_READ, reg_index_type'($urandom_range(7)),
                   pins_type'($urandom_range(255)), pins_type'($urandom_range(255)));
      end else if (pick < 95) begin
         send_word(ACT_WRITE, reg_index_type'($urandom_range(7)),
                   pins_type'($urandom_range(255)), pins_type'($urandom_range(255)));
      end else begin
         send_word(ACT_NONE, reg_index_type'($urandom_range(7)),
                   pins_type'($urandom_range(255)), pins_type'($urandom_range(255)));
      end
   endtask

   task automatic run_phase(int count, int idle, int stall, pins_type level,
                            pins_type both, pins_type rising);
      set_sense(level, both, rising);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      repeat (count) send_random_word();
      drain_results();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // falling-edge sensing on every pin after reset
      send_word(ACT_WRITE, REG_MASK,       8'hFF, 8'h00);
      send_word(ACT_TICK,  REG_DATA,       8'h00, 8'hFF);
      send_word(ACT_TICK,  REG_DIGITAL_EN, 8'hFF, 8'h00);
      send_word(ACT_READ,  REG_RAW_STATUS, 8'h00, 8'h00);
      send_word(ACT_READ,  REG_MASKED,     8'h00, 8'h00);
      send_word(ACT_WRITE, REG_RAW_STATUS, 8'h00, 8'h00);
      send_word(ACT_WRITE, REG_MASKED,     8'h00, 8'h00);
      send_word(ACT_READ,  REG_CLEAR,      8'h00, 8'h00);
      send_word(ACT_WRITE, REG_CLEAR,      8'h0F, 8'h00);
      send_word(ACT_READ,  REG_RAW_STATUS, 8'h00, 8'h00);
      send_word(ACT_WRITE, REG_DIRECTION,  8'hF0, 8'h00);
      send_word(ACT_WRITE, REG_DATA,       8'hA5, 8'h00);
      send_word(ACT_TICK,  REG_DATA,       8'h00, 8'h3C);
      send_word(ACT_READ,  REG_DATA,       8'h00, 8'h00);
      send_word(ACT_WRITE, REG_ALTFUNC,    8'hFF, 8'h00);
      send_word(ACT_WRITE, REG_DIGITAL_EN, 8'hFF, 8'h00);
      send_word(ACT_READ,  REG_ALTFUNC,    8'h00, 8'h00);
      send_word(ACT_READ,  REG_DIGITAL_EN, 8'h00, 8'h00);
      send_word(ACT_READ,  REG_DIRECTION,  8'h00, 8'h00);
      send_word(ACT_READ,  REG_MASK,       8'h00, 8'h00);
      send_word(ACT_NONE,  REG_DIGITAL_EN, 8'hFF, 8'hFF);
      send_word(ACT_WRITE, REG_CLEAR,      8'hFF, 8'h00);
      drain_results();

      // level pins on the upper half, both-edges set everywhere
      set_sense(8'hF0, 8'hFF, 8'hCC);
      write_csr(CSR_UNUSED, 8'hFF);
      send_word(ACT_TICK,  REG_DATA,       8'h00, 8'hFF);
      send_word(ACT_WRITE, REG_CLEAR,      8'hFF, 8'h00);
      send_word(ACT_READ,  REG_RAW_STATUS, 8'h00, 8'h00);
      send_word(ACT_TICK,  REG_DATA,       8'h00, 8'hFF);
      send_word(ACT_READ,  REG_RAW_STATUS, 8'h00, 8'h00);
      drain_results();
      last_pins = 8'hFF;

      run_phase(290, 0, 0, 8'h00, 8'h00, 8'h00);
      run_phase(290, 49, 0, 8'hFF, 8'hFF, 8'hFF);
      run_phase(290, 0, 49, pins_type'($urandom_range(255)), pins_type'($urandom_range(255)),
                pins_type'($urandom_range(255)));
      run_phase(290, 11, 11, pins_type'($urandom_range(255)), pins_type'($urandom_range(255)),
                pins_type'($urandom_range(255)));

      // fill the block behind a long rsp hold-off
      set_sense(pins_type'($urandom_range(255)), pins_type'($urandom_range(255)),
                pins_type'($urandom_range(255)));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_id        = hold_id + 1;
      repeat (260) send_random_word();
      drain_results();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && results_waiting == 0)
         $display("gpio_port_interrupt_detect test passed");
      else
         $display("gpio_port_interrupt_detect test failed");
      $finish;
   end

endmodule

// File: gpio_port_interrupt_detect.f
src/gpio_pid_pkg.sv
src/gpio_port_interrupt_detect.sv
test/gpio_port_interrupt_detect_checker.sv
test/gpio_port_interrupt_detect_test.sv
